// File: src/simt_pkg.sv
package simt_pkg;

  localparam int unsigned SIMT_MAX_INTERVALS = 32;
  localparam int unsigned SIMT_VALUE_BITS    = 16;

  localparam int unsigned SIMT_FIELD_BITS  = 16;
  localparam int unsigned SIMT_STATUS_BITS = 3;
  localparam int unsigned SIMT_COUNT_BITS  = 6;

  localparam logic [SIMT_STATUS_BITS-1:0] STATUS_NEW      = 3'd0;
  localparam logic [SIMT_STATUS_BITS-1:0] STATUS_MERGED   = 3'd1;
  localparam logic [SIMT_STATUS_BITS-1:0] STATUS_COVERED  = 3'd2;
  localparam logic [SIMT_STATUS_BITS-1:0] STATUS_DROPPED  = 3'd3;
  localparam logic [SIMT_STATUS_BITS-1:0] STATUS_INTERVAL = 3'd4;
  localparam logic [SIMT_STATUS_BITS-1:0] STATUS_EMPTY    = 3'd5;

  localparam logic FUNC_ADD  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Command broadcast from the controller to every cell of the chain.
  typedef enum logic [2:0] {
    OP_IDLE,
    OP_EVAL,
    OP_MERGE,
    OP_EXT_PREV,
    OP_EXT_NEXT,
    OP_INSERT,
    OP_ROTATE
  } op_e;

  // Per-cell findings that the controller reduces over the whole chain.
  typedef struct packed {
    logic covered;
    logic join_prev;
    logic join_next;
  } cell_flag_t;

endpackage

// File: src/simt_cell.sv
module simt_cell #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  simt_pkg::op_e         op_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  occ_i,
  input  logic                  occ_up_i,
  input  logic                  le_lo_i,
  input  logic                  le_up_i,
  input  logic [VALUE_BITS-1:0] lo_start_i,
  input  logic [VALUE_BITS-1:0] lo_end_i,
  input  logic [VALUE_BITS-1:0] up_start_i,
  input  logic [VALUE_BITS-1:0] up_end_i,
  input  logic [VALUE_BITS-1:0] head_start_i,
  input  logic [VALUE_BITS-1:0] head_end_i,
  output logic [VALUE_BITS-1:0] start_o,
  output logic [VALUE_BITS-1:0] end_o,
  output logic                  le_o,
  output simt_pkg::cell_flag_t  flag_o
);
  import simt_pkg::*;

  logic [VALUE_BITS-1:0] start_q;
  logic [VALUE_BITS-1:0] end_q;
  logic                  le_q;
  logic                  cov_q;
  logic                  adjp_q;
  logic                  adjn_q;
  logic                  is_prev;
  logic                  is_pos;
  logic                  is_tail;

  // This cell holds the interval just below the value, or sits at the
  // insertion point just above it.
  assign is_prev = le_q && !le_up_i;
  assign is_pos  = !le_q && le_lo_i;
  assign is_tail = occ_i && !occ_up_i;

  assign flag_o.covered   = is_prev && cov_q;
  assign flag_o.join_prev = is_prev && adjp_q;
  assign flag_o.join_next = is_pos && occ_i && adjn_q;

  assign start_o = start_q;
  assign end_o   = end_q;
  assign le_o    = le_q;

  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_EVAL: begin
        le_q   <= occ_i && (start_q <= value_i);
        cov_q  <= end_q >= value_i;
        adjp_q <= ({1'b0, end_q} + 1'b1) == {1'b0, value_i};
        adjn_q <= ({1'b0, value_i} + 1'b1) == {1'b0, start_q};
      end
      OP_MERGE: begin
        if (is_prev) begin
          end_q <= up_end_i;
        end else if (!le_q) begin
          start_q <= up_start_i;
          end_q   <= up_end_i;
        end
      end
      OP_EXT_PREV: begin
        if (is_prev) begin
          end_q <= value_i;
        end
      end
      OP_EXT_NEXT: begin
        if (is_pos) begin
          start_q <= value_i;
        end
      end
      OP_INSERT: begin
        if (is_pos) begin
          start_q <= value_i;
          end_q   <= value_i;
        end else if (!le_q) begin
          start_q <= lo_start_i;
          end_q   <= lo_end_i;
        end
      end
      OP_ROTATE: begin
        if (is_tail) begin
          start_q <= head_start_i;
          end_q   <= head_end_i;
        end else begin
          start_q <= up_start_i;
          end_q   <= up_end_i;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/sorted_interval_merge_table_top.sv
// Sorted set of disjoint, non-adjacent integer intervals.
//
// Command channel: a transaction is taken at a rising edge where start is
// high and busy is low. func_i selects an add of value_i or a readout of the
// whole table. Results leave on the result channel: each transaction there
// lasts exactly one cycle, marked by result_valid_o, and cannot be held off.
// last_o marks the final result that belongs to one command.
//
// An add gives one result. It first compares the value against every cell
// at once (eval state), then applies the change (apply state), from which
// its result is registered; a new command can already be taken while the
// change is applied. A readout gives one result per held interval in
// ascending order, the first registered from the first read state, by rotating
// the chain of cells one place per cycle and reporting the head cell; it
// leaves the table in its original order.
// An empty table answers a readout with a single empty result.
//
// Reset clears the interval count and the controller; the cell contents are
// left as they are and are only read below the count.
module sorted_interval_merge_table_top #(
  parameter int unsigned MAX_INTERVALS = simt_pkg::SIMT_MAX_INTERVALS,
  parameter int unsigned VALUE_BITS    = simt_pkg::SIMT_VALUE_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  func_i,
  input  logic [simt_pkg::SIMT_FIELD_BITS-1:0]  value_i,
  output logic                                  result_valid_o,
  output logic [simt_pkg::SIMT_STATUS_BITS-1:0] status_o,
  output logic [simt_pkg::SIMT_FIELD_BITS-1:0]  range_start_o,
  output logic [simt_pkg::SIMT_FIELD_BITS-1:0]  range_end_o,
  output logic [simt_pkg::SIMT_COUNT_BITS-1:0]  interval_count_o,
  output logic                                  last_o
);
  import simt_pkg::*;

  localparam int unsigned CountBits = $clog2(MAX_INTERVALS + 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StEval  = 2'd1;
  localparam logic [1:0] StApply = 2'd2;
  localparam logic [1:0] StRead  = 2'd3;

  logic [1:0]            state_q, state_d;
  logic [CountBits-1:0]  count_q, count_d;
  logic [CountBits-1:0]  rd_q, rd_d;
  logic [VALUE_BITS-1:0] value_q, value_d;

  logic                        valid_q, valid_d;
  logic [SIMT_STATUS_BITS-1:0] status_q, status_d;
  logic [SIMT_FIELD_BITS-1:0]  rstart_q, rstart_d;
  logic [SIMT_FIELD_BITS-1:0]  rend_q, rend_d;
  logic [SIMT_COUNT_BITS-1:0]  icount_q, icount_d;
  logic                        last_q, last_d;

  logic [VALUE_BITS-1:0] cell_start [MAX_INTERVALS];
  logic [VALUE_BITS-1:0] cell_end   [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] cell_le;
  logic [MAX_INTERVALS-1:0] occ;
  cell_flag_t               cell_flag [MAX_INTERVALS];

  op_e                   op;
  logic                  accept;
  logic                  rd_last;
  logic                  any_covered;
  logic                  any_join_prev;
  logic                  any_join_next;
  logic [31:0]           value_ext;
  logic [31:0]           head_start_ext;
  logic [31:0]           head_end_ext;
  logic [31:0]           count_ext;

  assign value_ext      = 32'(value_i);
  assign head_start_ext = 32'(cell_start[0]);
  assign head_end_ext   = 32'(cell_end[0]);
  assign count_ext      = 32'(count_d);

  // A readout ends once the entry before the count has been shown; an empty
  // readout ends with its first result.
  assign rd_last = (count_q == '0) || (rd_q == count_q - CountBits'(1));
  assign busy    = (state_q == StEval) || ((state_q == StRead) && !rd_last);
  assign accept  = start && !busy;

  always_comb begin
    for (int k = 0; k < MAX_INTERVALS; k++) begin
      occ[k] = CountBits'(k) < count_q;
    end
  end

  // The chain marks at most one cell as the lower or upper neighbor, so a
  // plain OR over all cells picks out its finding.
  always_comb begin
    any_covered   = 1'b0;
    any_join_prev = 1'b0;
    any_join_next = 1'b0;
    for (int k = 0; k < MAX_INTERVALS; k++) begin
      any_covered   = any_covered   | cell_flag[k].covered;
      any_join_prev = any_join_prev | cell_flag[k].join_prev;
      any_join_next = any_join_next | cell_flag[k].join_next;
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    rd_d     = rd_q;
    value_d  = value_q;
    op       = OP_IDLE;
    valid_d  = 1'b0;
    status_d = status_q;
    rstart_d = rstart_q;
    rend_d   = rend_q;
    last_d   = last_q;

    unique case (state_q)
      StEval: begin
        op      = OP_EVAL;
        state_d = StApply;
      end
      StApply: begin
        valid_d  = 1'b1;
        rstart_d = '0;
        rend_d   = '0;
        last_d   = 1'b1;
        priority if (any_covered) begin
          status_d = STATUS_COVERED;
        end else if (any_join_prev && any_join_next) begin
          op       = OP_MERGE;
          status_d = STATUS_MERGED;
          count_d  = count_q - CountBits'(1);
        end else if (any_join_prev) begin
          op       = OP_EXT_PREV;
          status_d = STATUS_MERGED;
        end else if (any_join_next) begin
          op       = OP_EXT_NEXT;
          status_d = STATUS_MERGED;
        end else if (count_q == CountBits'(MAX_INTERVALS)) begin
          status_d = STATUS_DROPPED;
        end else begin
          op       = OP_INSERT;
          status_d = STATUS_NEW;
          count_d  = count_q + CountBits'(1);
        end
        state_d = StIdle;
      end
      StRead: begin
        valid_d = 1'b1;
        last_d  = rd_last;
        if (count_q == '0) begin
          status_d = STATUS_EMPTY;
          rstart_d = '0;
          rend_d   = '0;
        end else begin
          op       = OP_ROTATE;
          status_d = STATUS_INTERVAL;
          rstart_d = head_start_ext[SIMT_FIELD_BITS-1:0];
          rend_d   = head_end_ext[SIMT_FIELD_BITS-1:0];
        end
        rd_d = rd_q + CountBits'(1);
        if (rd_last) begin
          state_d = StIdle;
        end
      end
      default: begin
      end
    endcase

    // A new command may follow straight on from the final cycle of the
    // previous one.
    if (accept) begin
      if (func_i == FUNC_ADD) begin
        state_d = StEval;
        value_d = value_ext[VALUE_BITS-1:0];
      end else begin
        state_d = StRead;
        rd_d    = '0;
      end
    end

    icount_d = count_ext[SIMT_COUNT_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      rd_q    <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rd_q    <= rd_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
    rstart_q <= rstart_d;
    rend_q   <= rend_d;
    icount_q <= icount_d;
    last_q   <= last_d;
  end

  for (genvar k = 0; k < MAX_INTERVALS; k++) begin : g_cell
    logic                  occ_up;
    logic                  le_lo;
    logic                  le_up;
    logic [VALUE_BITS-1:0] lo_start;
    logic [VALUE_BITS-1:0] lo_end;
    logic [VALUE_BITS-1:0] up_start;
    logic [VALUE_BITS-1:0] up_end;

    if (k == 0) begin : g_first
      assign le_lo    = 1'b1;
      assign lo_start = '0;
      assign lo_end   = '0;
    end else begin : g_inner_lo
      assign le_lo    = cell_le[k-1];
      assign lo_start = cell_start[k-1];
      assign lo_end   = cell_end[k-1];
    end

    if (k == MAX_INTERVALS - 1) begin : g_final
      assign occ_up   = 1'b0;
      assign le_up    = 1'b0;
      assign up_start = '0;
      assign up_end   = '0;
    end else begin : g_inner_up
      assign occ_up   = occ[k+1];
      assign le_up    = cell_le[k+1];
      assign up_start = cell_start[k+1];
      assign up_end   = cell_end[k+1];
    end

    simt_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .value_i     (value_q),
      .occ_i       (occ[k]),
      .occ_up_i    (occ_up),
      .le_lo_i     (le_lo),
      .le_up_i     (le_up),
      .lo_start_i  (lo_start),
      .lo_end_i    (lo_end),
      .up_start_i  (up_start),
      .up_end_i    (up_end),
      .head_start_i(cell_start[0]),
      .head_end_i  (cell_end[0]),
      .start_o     (cell_start[k]),
      .end_o       (cell_end[k]),
      .le_o        (cell_le[k]),
      .flag_o      (cell_flag[k])
    );
  end

  assign result_valid_o   = valid_q;
  assign status_o         = status_q;
  assign range_start_o    = rstart_q;
  assign range_end_o      = rend_q;
  assign interval_count_o = icount_q;
  assign last_o           = last_q;

endmodule
